FILE: rtl/core/acm_pkg.sv
// Shared types, constants and register codes for the aural cue mapper.
package acm_pkg;

    localparam int DIV_W      = 31;
    localparam int DEN_W      = 17;
    localparam int DIV_STAGES = DIV_W;

    localparam logic [15:0] FREQ_START_Q    = 16'd384;
    localparam logic [15:0] FREQ_STALL_Q    = 16'd5120;
    localparam logic [17:0] PERIOD_MAX      = 18'd262143;
    localparam logic [14:0] RECIP_25        = 15'd20972;
    localparam logic [15:0] RECIP_5         = 16'd52429;

    typedef enum logic [2:0] {
        REGIME_CRUISE  = 3'd0,
        REGIME_FAST    = 3'd1,
        REGIME_ONSPEED = 3'd2,
        REGIME_SLOW    = 3'd3,
        REGIME_WARN    = 3'd4
    } regime_t;

    typedef enum logic [2:0] {
        CFG_CRUISE     = 3'd0,
        CFG_REFERENCE  = 3'd1,
        CFG_STALL      = 3'd2,
        CFG_WARN       = 3'd3,
        CFG_BIAS       = 3'd4,
        CFG_FULL_SCALE = 3'd5,
        CFG_FPS        = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic signed [15:0] alpha;
        logic signed [15:0] beta;
    } sample_t;

    typedef struct packed {
        regime_t            regime;
        logic signed [15:0] left_gain;
        logic signed [15:0] right_gain;
        logic [15:0]        tone_period;
        logic [17:0]        pulse_period;
        logic [17:0]        pwm_on_time;
        logic [15:0]        ramp_time;
    } cue_t;

    typedef struct packed {
        logic signed [15:0] cruise;
        logic signed [15:0] reference;
        logic signed [15:0] stall_angle;
        logic signed [15:0] warn;
        logic signed [15:0] bias;
        logic [14:0]        full_scale;
        logic [17:0]        fps;
    } cfg_t;

    typedef struct packed {
        regime_t          regime;
        logic             gl_neg;
        logic             gr_neg;
        logic             fq_neg;
        logic             flat;
        logic [DIV_W-1:0] gl_num;
        logic [DIV_W-1:0] gr_num;
        logic [DEN_W-1:0] gain_den;
        logic [DIV_W-1:0] fq_num;
        logic [DEN_W-1:0] fq_den;
    } front_t;

    typedef struct packed {
        regime_t regime;
        logic    gl_neg;
        logic    gr_neg;
        logic    fq_neg;
        logic    flat;
    } side1_t;

    typedef struct packed {
        regime_t            regime;
        logic signed [15:0] left_gain;
        logic signed [15:0] right_gain;
    } side2_t;

endpackage

FILE: rtl/core/acm_divider.sv
// Pipelined restoring divider, one quotient bit per stage.
module acm_divider
    import acm_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [DIV_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [DIV_W-1:0] quot,
    output logic [DEN_W-1:0] rem
);

    logic [DIV_W-1:0] work_reg  [DIV_STAGES];
    logic [DEN_W-1:0] rem_reg   [DIV_STAGES];
    logic [DEN_W-1:0] den_reg   [DIV_STAGES];
    logic [DIV_W-1:0] work_next [DIV_STAGES];
    logic [DEN_W-1:0] rem_next  [DIV_STAGES];
    logic [DEN_W-1:0] den_next  [DIV_STAGES];

    always_comb
    begin
        logic [DIV_W-1:0] w_in;
        logic [DEN_W-1:0] r_in;
        logic [DEN_W-1:0] d_in;
        logic [DEN_W:0]   shifted;
        logic [DEN_W+1:0] trial;
        for (int i = 0; i < DIV_STAGES; i++)
        begin
            if (i == 0)
            begin
                w_in = num;
                r_in = '0;
                d_in = den;
            end
            else
            begin
                w_in = work_reg[i-1];
                r_in = rem_reg[i-1];
                d_in = den_reg[i-1];
            end
            shifted = {r_in, w_in[DIV_W-1]};
            trial   = {1'b0, shifted} - {2'b00, d_in};
            if (trial[DEN_W+1])
                rem_next[i] = shifted[DEN_W-1:0];
            else
                rem_next[i] = trial[DEN_W-1:0];
            work_next[i] = {w_in[DIV_W-2:0], ~trial[DEN_W+1]};
            den_next[i]  = d_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < DIV_STAGES; i++)
            begin
                work_reg[i] <= work_next[i];
                rem_reg[i]  <= rem_next[i];
                den_reg[i]  <= den_next[i];
            end
        end
    end

    assign quot = work_reg[DIV_STAGES-1];
    assign rem  = rem_reg[DIV_STAGES-1];

endmodule

FILE: rtl/core/acm_front.sv
// Regime sort and divider operand preparation, two register stages.
module acm_front
    import acm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  cfg_t    cfg,
    input  logic    valid,
    input  sample_t sample,
    output logic    front_valid,
    output front_t  front
);

    logic               v1_reg;
    regime_t            regime1_reg;
    logic signed [17:0] nl1_reg;
    logic signed [17:0] nr1_reg;
    logic [14:0]        fs1_reg;
    logic signed [16:0] nx1_reg;
    logic signed [16:0] dx1_reg;
    logic               slow1_reg;

    regime_t            regime1_next;
    logic signed [17:0] nl1_next;
    logic signed [17:0] nr1_next;
    logic [14:0]        fs1_next;
    logic signed [16:0] nx1_next;
    logic signed [16:0] dx1_next;

    logic               v2_reg;
    front_t             front_reg;
    front_t             front_next;

    always_comb
    begin
        logic signed [21:0] a_x;
        logic signed [21:0] r_x;
        logic signed [21:0] a20;
        logic signed [21:0] r20;
        logic signed [21:0] d_x;
        logic signed [16:0] num;
        logic signed [16:0] x0;
        logic signed [16:0] x1;
        a_x = {{6{sample.alpha[15]}}, sample.alpha};
        r_x = {{6{cfg.reference[15]}}, cfg.reference};
        a20 = (a_x <<< 4) + (a_x <<< 2);
        r20 = (r_x <<< 4) + (r_x <<< 2);
        d_x = {{6{cfg.stall_angle[15]}}, cfg.stall_angle} - r_x;
        if (sample.alpha < cfg.cruise)
            regime1_next = REGIME_CRUISE;
        else if (a20 < r20 - d_x)
            regime1_next = REGIME_FAST;
        else if (a20 < r20 + d_x)
            regime1_next = REGIME_ONSPEED;
        else if (sample.alpha < cfg.warn)
            regime1_next = REGIME_SLOW;
        else
            regime1_next = REGIME_WARN;
        fs1_next = (cfg.full_scale == '0) ? 15'd1 : cfg.full_scale;
        num      = {sample.beta[15], sample.beta} + {cfg.bias[15], cfg.bias};
        nl1_next = $signed({3'b000, fs1_next}) - {num[16], num};
        nr1_next = $signed({3'b000, fs1_next}) + {num[16], num};
        if (regime1_next == REGIME_SLOW)
        begin
            x0 = {cfg.reference[15], cfg.reference};
            x1 = {cfg.warn[15], cfg.warn};
        end
        else
        begin
            x0 = {cfg.cruise[15], cfg.cruise};
            x1 = {cfg.reference[15], cfg.reference};
        end
        nx1_next = {sample.alpha[15], sample.alpha} - x0;
        dx1_next = x1 - x0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            regime1_reg <= regime1_next;
            nl1_reg     <= nl1_next;
            nr1_reg     <= nr1_next;
            fs1_reg     <= fs1_next;
            nx1_reg     <= nx1_next;
            dx1_reg     <= dx1_next;
            slow1_reg   <= (regime1_next == REGIME_SLOW);
            front_reg   <= front_next;
        end
    end

    always_comb
    begin
        logic signed [29:0] nx_x;
        logic signed [29:0] dy;
        logic signed [29:0] prod;
        logic [17:0]        mag_l;
        logic [17:0]        mag_r;
        logic [16:0]        mag_dx;
        nx_x  = {{13{nx1_reg[16]}}, nx1_reg};
        dy    = slow1_reg ? 30'sd2176 : 30'sd1280;
        prod  = nx_x * dy;
        mag_l = nl1_reg[17] ? 18'(-nl1_reg) : 18'(nl1_reg);
        mag_r = nr1_reg[17] ? 18'(-nr1_reg) : 18'(nr1_reg);
        mag_dx = dx1_reg[16] ? 17'(-dx1_reg) : 17'(dx1_reg);
        front_next.regime   = regime1_reg;
        front_next.gl_neg   = nl1_reg[17];
        front_next.gr_neg   = nr1_reg[17];
        front_next.fq_neg   = prod[29] ^ dx1_reg[16];
        front_next.flat     = (dx1_reg == '0);
        front_next.gl_num   = {mag_l[17:0], 13'd0};
        front_next.gr_num   = {mag_r[17:0], 13'd0};
        front_next.gain_den = {2'b00, fs1_reg};
        front_next.fq_num   = prod[29] ? DIV_W'(-prod) : DIV_W'(prod);
        front_next.fq_den   = mag_dx;
    end

    assign front_valid = v2_reg;
    assign front       = front_reg;

endmodule

FILE: rtl/core/aoa_aural_cue_mapper.sv
// Top level of the angle-of-attack aural cue mapper.
//
// Usage: one sample word (alpha, beta) enters on the sample channel
// (sample_valid / sample_stall) and one cue word leaves on the cue channel
// (cue_valid / cue_stall) for every sample, in order.
// From acceptance to the cue word being presented a word passes two front
// stages, a 31-stage divider for gains and PWM frequency, one post stage,
// a 31-stage divider for the PWM period and the output register; the two
// divider ranks set the depth. One word per cycle while not stalled.
// Write the registers through wr_en / wr_index / wr_data only while idle;
// the block does not enforce this. A write to an unknown index is dropped.
// Reset clears all valid bits and loads the register defaults.
// When the receiver stalls with a word presented, the whole pipeline holds
// and sample_stall rises in the same cycle; bubbles travel as empty stages.
module aoa_aural_cue_mapper
    import acm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sample_valid,
    output logic        sample_stall,
    input  sample_t     sample,
    output logic        cue_valid,
    input  logic        cue_stall,
    output cue_t        cue,
    input  logic        wr_en,
    input  logic [2:0]  wr_index,
    input  logic [17:0] wr_data
);

    cfg_t   cfg_reg;
    logic   advance;
    logic   front_valid;
    front_t front;

    logic [28:0] tf_prod_reg;
    logic [26:0] ts_prod_reg;
    logic [29:0] ramp_prod_reg;
    logic [31:0] on_prod_reg;

    logic             v1_reg    [DIV_STAGES];
    side1_t           side1_reg [DIV_STAGES];
    logic [DIV_W-1:0] gl_q, gr_q, fq_q;
    logic [DEN_W-1:0] gl_r, gr_r, fq_r;

    logic             vp_reg;
    side2_t           sidep_reg;
    logic [DIV_W-1:0] pnum_reg;
    logic [DEN_W-1:0] pden_reg;
    side2_t           sidep_next;
    logic [15:0]      fq_next;

    logic             v2_reg    [DIV_STAGES];
    side2_t           side2_reg [DIV_STAGES];
    logic [DIV_W-1:0] pp_q;
    logic [DEN_W-1:0] pp_r;

    logic cue_valid_reg;
    cue_t cue_reg;
    cue_t cue_next;

    assign advance      = !(cue_valid_reg && cue_stall);
    assign sample_stall = !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cruise      <= 16'sd1280;
            cfg_reg.reference   <= 16'sd2560;
            cfg_reg.stall_angle <= 16'sd3840;
            cfg_reg.warn        <= 16'sd3584;
            cfg_reg.bias        <= 16'sd0;
            cfg_reg.full_scale  <= 15'd5120;
            cfg_reg.fps         <= 18'd48000;
        end
        else if (wr_en)
        begin
            case (cfg_index_t'(wr_index))
                CFG_CRUISE:     cfg_reg.cruise      <= wr_data[15:0];
                CFG_REFERENCE:  cfg_reg.reference   <= wr_data[15:0];
                CFG_STALL:      cfg_reg.stall_angle <= wr_data[15:0];
                CFG_WARN:       cfg_reg.warn        <= wr_data[15:0];
                CFG_BIAS:       cfg_reg.bias        <= wr_data[15:0];
                CFG_FULL_SCALE: cfg_reg.full_scale  <= wr_data[14:0];
                CFG_FPS:        cfg_reg.fps         <= wr_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        tf_prod_reg   <= cfg_reg.fps[17:4] * RECIP_25;
        ts_prod_reg   <= cfg_reg.fps[17:6] * RECIP_25;
        ramp_prod_reg <= cfg_reg.fps[17:3] * RECIP_25;
        on_prod_reg   <= cfg_reg.fps[17:2] * RECIP_5;
    end

    acm_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (advance),
        .cfg         (cfg_reg),
        .valid       (sample_valid),
        .sample      (sample),
        .front_valid (front_valid),
        .front       (front)
    );

    acm_divider u_div_left (
        .clk (clk), .en (advance), .num (front.gl_num), .den (front.gain_den),
        .quot (gl_q), .rem (gl_r)
    );

    acm_divider u_div_right (
        .clk (clk), .en (advance), .num (front.gr_num), .den (front.gain_den),
        .quot (gr_q), .rem (gr_r)
    );

    acm_divider u_div_freq (
        .clk (clk), .en (advance), .num (front.fq_num), .den (front.fq_den),
        .quot (fq_q), .rem (fq_r)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_STAGES; i++)
            begin
                v1_reg[i] <= 1'b0;
                v2_reg[i] <= 1'b0;
            end
            vp_reg        <= 1'b0;
            cue_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg[0] <= front_valid;
            v2_reg[0] <= vp_reg;
            for (int i = 1; i < DIV_STAGES; i++)
            begin
                v1_reg[i] <= v1_reg[i-1];
                v2_reg[i] <= v2_reg[i-1];
            end
            vp_reg        <= v1_reg[DIV_STAGES-1];
            cue_valid_reg <= v2_reg[DIV_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            side1_reg[0].regime <= front.regime;
            side1_reg[0].gl_neg <= front.gl_neg;
            side1_reg[0].gr_neg <= front.gr_neg;
            side1_reg[0].fq_neg <= front.fq_neg;
            side1_reg[0].flat   <= front.flat;
            side2_reg[0]        <= sidep_reg;
            for (int i = 1; i < DIV_STAGES; i++)
            begin
                side1_reg[i] <= side1_reg[i-1];
                side2_reg[i] <= side2_reg[i-1];
            end
            sidep_reg <= sidep_next;
            pnum_reg  <= DIV_W'({cfg_reg.fps, 8'd0});
            pden_reg  <= DEN_W'(fq_next);
            cue_reg   <= cue_next;
        end
    end

    function automatic logic signed [32:0] signed_quot(
        input logic             neg,
        input logic [DIV_W-1:0] q,
        input logic [DEN_W-1:0] r
    );
        logic signed [32:0] mag;
        mag = $signed({2'b00, q});
        if (neg)
            return -(mag + ((r != '0) ? 33'sd1 : 33'sd0));
        return mag;
    endfunction

    function automatic logic signed [15:0] gain_sat(input logic signed [32:0] g);
        if (g > 33'sd16384)
            return 16'sd16384;
        if (g < -33'sd32768)
            return -16'sd32768;
        return g[15:0];
    endfunction

    always_comb
    begin
        side1_t             s;
        logic signed [32:0] fd;
        logic signed [33:0] f;
        s  = side1_reg[DIV_STAGES-1];
        fd = signed_quot(s.fq_neg, fq_q, fq_r);
        sidep_next.regime     = s.regime;
        sidep_next.left_gain  = gain_sat(signed_quot(s.gl_neg, gl_q, gl_r));
        sidep_next.right_gain = gain_sat(signed_quot(s.gr_neg, gr_q, gr_r));
        f = $signed({18'd0, FREQ_START_Q}) + $signed({fd[32], fd});
        if (s.regime == REGIME_WARN)
            fq_next = FREQ_STALL_Q;
        else if (s.flat)
            fq_next = FREQ_START_Q;
        else if (f < 34'sd1)
            fq_next = 16'd1;
        else if (f > 34'sd65535)
            fq_next = 16'hFFFF;
        else
            fq_next = f[15:0];
    end

    acm_divider u_div_period (
        .clk (clk), .en (advance), .num (pnum_reg), .den (pden_reg),
        .quot (pp_q), .rem (pp_r)
    );

    always_comb
    begin
        side2_t      s;
        logic [17:0] pp;
        s  = side2_reg[DIV_STAGES-1];
        pp = (pp_q > DIV_W'(PERIOD_MAX)) ? PERIOD_MAX : pp_q[17:0];
        cue_next.regime       = s.regime;
        cue_next.left_gain    = s.left_gain;
        cue_next.right_gain   = s.right_gain;
        cue_next.tone_period  = '0;
        cue_next.pulse_period = '0;
        cue_next.pwm_on_time  = '0;
        cue_next.ramp_time    = '0;
        case (s.regime)
            REGIME_CRUISE:
            begin
                cue_next.left_gain  = '0;
                cue_next.right_gain = '0;
            end
            REGIME_ONSPEED:
            begin
                cue_next.tone_period  = 16'(tf_prod_reg[28:19]);
                cue_next.pulse_period = 18'(on_prod_reg[31:18]);
                cue_next.pwm_on_time  = 18'(on_prod_reg[31:18]);
            end
            REGIME_FAST, REGIME_SLOW, REGIME_WARN:
            begin
                cue_next.tone_period  = (s.regime == REGIME_FAST) ?
                                        16'(tf_prod_reg[28:19]) : 16'(ts_prod_reg[26:19]);
                cue_next.pulse_period = pp;
                cue_next.pwm_on_time  = pp >> 1;
                cue_next.ramp_time    = 16'(ramp_prod_reg[29:19]);
            end
            default:
            begin
                cue_next.left_gain  = '0;
                cue_next.right_gain = '0;
            end
        endcase
    end

    assign cue_valid = cue_valid_reg;
    assign cue       = cue_reg;

`ifndef ASSERT_OFF
    a_cruise_silent: assert property (@(posedge clk) disable iff (!rst_n)
        cue_valid && cue.regime == REGIME_CRUISE |->
            cue.left_gain == '0 && cue.right_gain == '0 && cue.pulse_period == '0)
        else $error("cruise word carries non-zero cue");

    a_onspeed_steady: assert property (@(posedge clk) disable iff (!rst_n)
        cue_valid && cue.regime == REGIME_ONSPEED |->
            cue.pwm_on_time == cue.pulse_period && cue.ramp_time == '0)
        else $error("onspeed word not steady tone");

    a_pulsed_half: assert property (@(posedge clk) disable iff (!rst_n)
        cue_valid && (cue.regime == REGIME_FAST || cue.regime == REGIME_SLOW ||
                      cue.regime == REGIME_WARN) |->
            cue.pwm_on_time == (cue.pulse_period >> 1))
        else $error("pulsed word on-time not half period");

    a_gain_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cue_valid |-> cue.left_gain <= 16'sd16384 && cue.right_gain <= 16'sd16384)
        else $error("gain above unity");
`endif

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the angle-of-attack aural cue mapper.
module testbench
    import acm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        sample_valid = 1'b0;
    logic        sample_stall;
    sample_t     sample = '0;
    logic        cue_valid;
    logic        cue_stall = 1'b0;
    cue_t        cue;
    logic        wr_en = 1'b0;
    logic [2:0]  wr_index = '0;
    logic [17:0] wr_data = '0;

    cfg_t        cfg;
    cue_t        cue_fifo[$];
    int          mismatches = 0;
    int          cues_seen = 0;
    int          words_sent = 0;
    int          regime_hits[5];
    int          stall_mode = 0;

    aoa_aural_cue_mapper dut (.*);

    always #2 clk = ~clk;

    function automatic longint fdiv(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && ((n < 0) != (d < 0)))
            q = q - 1;
        return q;
    endfunction

    function automatic logic signed [15:0] gain(longint num, longint fs);
        longint g;
        g = fdiv(8192 * num, fs);
        if (g > 16384) g = 16384;
        if (g < -32768) g = -32768;
        return g[15:0];
    endfunction

    function automatic longint lerp(longint y0, longint y1, longint x0, longint x1, longint x);
        if (x1 == x0)
            return y0;
        return y0 + fdiv((x - x0) * (y1 - y0), x1 - x0);
    endfunction

    function automatic cue_t predict_cue(sample_t s);
        cue_t    c;
        longint  a, b, y, r, st, w, fs, fps, d, num, fq, pper;
        regime_t rg;
        c = '0;
        a = s.alpha; b = s.beta;
        y = cfg.cruise; r = cfg.reference; st = cfg.stall_angle; w = cfg.warn;
        fs = cfg.full_scale; fps = cfg.fps;
        if (fs == 0) fs = 1;
        d = st - r;
        if (a < y) rg = REGIME_CRUISE;
        else if (20 * a < 20 * r - d) rg = REGIME_FAST;
        else if (20 * a < 20 * r + d) rg = REGIME_ONSPEED;
        else if (a < w) rg = REGIME_SLOW;
        else rg = REGIME_WARN;
        c.regime = rg;
        if (rg != REGIME_CRUISE) begin
            num = b + cfg.bias;
            c.left_gain = gain(fs - num, fs);
            c.right_gain = gain(fs + num, fs);
            c.tone_period = (rg == REGIME_FAST || rg == REGIME_ONSPEED) ?
                            16'(fps / 400) : 16'(fps / 1600);
            if (rg == REGIME_ONSPEED) begin
                c.pulse_period = 18'(fps / 20);
                c.pwm_on_time = 18'(fps / 20);
                c.ramp_time = '0;
            end
            else begin
                if (rg == REGIME_FAST) fq = lerp(384, 1664, y, r, a);
                else if (rg == REGIME_SLOW) fq = lerp(384, 2560, r, w, a);
                else fq = 5120;
                if (fq < 1) fq = 1;
                if (fq > 65535) fq = 65535;
                pper = (fps * 256) / fq;
                if (pper > 262143) pper = 262143;
                c.pulse_period = pper[17:0];
                c.pwm_on_time = pper[17:0] / 2;
                c.ramp_time = 16'(fps / 200);
            end
        end
        return c;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch on %s: got %0d, want %0d (cue %0d)", what, got, want, cues_seen);
        mismatches++;
    endtask

    task automatic write_reg(cfg_index_t idx, logic [17:0] value);
        @(negedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= value;
        @(negedge clk);
        wr_en <= 1'b0;
        case (idx)
            CFG_CRUISE:     cfg.cruise = value[15:0];
            CFG_REFERENCE:  cfg.reference = value[15:0];
            CFG_STALL:      cfg.stall_angle = value[15:0];
            CFG_WARN:       cfg.warn = value[15:0];
            CFG_BIAS:       cfg.bias = value[15:0];
            CFG_FULL_SCALE: cfg.full_scale = value[14:0];
            CFG_FPS:        cfg.fps = value;
            default:        ;
        endcase
    endtask

    task automatic write_unknown(logic [17:0] value);
        @(negedge clk);
        wr_en <= 1'b1;
        wr_index <= 3'd7;
        wr_data <= value;
        @(negedge clk);
        wr_en <= 1'b0;
    endtask

    // Called at a falling edge; leaves at the falling edge after acceptance.
    task automatic send_word(logic [15:0] alpha, logic [15:0] beta);
        sample_valid <= 1'b1;
        sample.alpha <= alpha;
        sample.beta <= beta;
        do
            @(posedge clk);
        while (sample_stall);
        cue_fifo.push_back(predict_cue('{alpha: alpha, beta: beta}));
        words_sent++;
        @(negedge clk);
    endtask

    task automatic end_burst();
        sample_valid <= 1'b0;
    endtask

    task automatic drain();
        while (cue_fifo.size() != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    task automatic random_words(int n);
        int left, burst, gap;
        int lo, hi;
        left = n;
        lo = cfg.cruise - 1024;
        hi = cfg.warn + 1024;
        while (left > 0) begin
            burst = $urandom_range(1, 20);
            for (int k = 0; k < burst && left > 0; k++) begin
                if ($urandom_range(0, 3) == 0)
                    send_word(16'($urandom), 16'($urandom));
                else
                    send_word(16'($urandom_range(0, hi - lo) + lo),
                              16'($urandom_range(0, 8000)) - 16'd4000);
                left--;
            end
            if ($urandom_range(0, 2) != 0) begin
                end_burst();
                gap = $urandom_range(1, 8);
                repeat (gap) @(negedge clk);
            end
        end
        end_burst();
    endtask

    task automatic test_defaults();
        send_word(16'h8000, 16'h0000);
        send_word(16'h7FFF, 16'h7FFF);
        send_word(16'd1280, 16'h8000);
        send_word(16'd1279, 16'd0);
        send_word(16'd2432, 16'd100);
        send_word(16'd2431, -16'sd100);
        send_word(16'd2560, 16'd5120);
        send_word(16'd2688, -16'sd5120);
        send_word(16'd2687, 16'd20000);
        send_word(16'd3583, -16'sd20000);
        send_word(16'd3584, 16'h7FFF);
        send_word(16'd1800, 16'h8000);
        send_word(16'd3000, 16'h7FFF);
        end_burst();
        drain();
    endtask

    task automatic test_extreme_config();
        write_reg(CFG_FULL_SCALE, 18'd0);
        write_reg(CFG_BIAS, 18'h08000);
        write_reg(CFG_FPS, 18'd8000);
        write_unknown(18'h3FFFF);
        send_word(16'd2000, 16'h8000);
        send_word(16'd3000, 16'h7FFF);
        send_word(16'd3700, 16'd0);
        end_burst();
        drain();
        write_reg(CFG_FULL_SCALE, 18'h7FFF);
        write_reg(CFG_BIAS, 18'h07FFF);
        write_reg(CFG_FPS, 18'h3FFFF);
        write_reg(CFG_CRUISE, 18'h08000);
        write_reg(CFG_REFERENCE, 18'h07FFF);
        write_reg(CFG_STALL, 18'h08000);
        write_reg(CFG_WARN, 18'h07FFF);
        send_word(16'h8000, 16'h7FFF);
        send_word(16'h0000, 16'h8000);
        send_word(16'h7FFF, 16'h0000);
        end_burst();
        drain();
        // equal end angles for both interpolations
        write_reg(CFG_CRUISE, 18'd2000);
        write_reg(CFG_REFERENCE, 18'd2000);
        write_reg(CFG_STALL, 18'd2000);
        write_reg(CFG_WARN, 18'd2000);
        send_word(16'd1999, 16'd1);
        send_word(16'd2000, 16'd1);
        send_word(16'd2001, 16'd1);
        end_burst();
        drain();
        // inverted thresholds: stall and warn below reference
        write_reg(CFG_CRUISE, 18'h0F000);
        write_reg(CFG_REFERENCE, 18'd100);
        write_reg(CFG_STALL, 18'd50);
        write_reg(CFG_WARN, 18'h0F800);
        for (int k = 0; k < 6; k++)
            send_word(16'($urandom), 16'($urandom));
        end_burst();
        drain();
    endtask

    task automatic test_random_settings();
        for (int p = 0; p < 5; p++) begin
            logic [15:0] c, r, s, w;
            c = 16'($urandom_range(0, 2000));
            r = c + 16'($urandom_range(0, 2000));
            s = r + 16'($urandom_range(0, 2000));
            w = r + 16'($urandom_range(0, 2000));
            write_reg(CFG_CRUISE, {2'b00, c});
            write_reg(CFG_REFERENCE, {2'b00, r});
            write_reg(CFG_STALL, {2'b00, s});
            write_reg(CFG_WARN, {2'b00, w});
            write_reg(CFG_BIAS, 18'($urandom_range(0, 2000)) - 18'd1000);
            write_reg(CFG_FULL_SCALE, 18'($urandom_range(1, 32767)));
            write_reg(CFG_FPS, 18'($urandom_range(8000, 192000)));
            stall_mode = p % 3;
            random_words(300);
            drain();
        end
        stall_mode = 0;
    endtask

    always @(negedge clk) begin
        case (stall_mode)
            0: cue_stall <= ($urandom_range(0, 3) == 0);
            1: cue_stall <= 1'b0;
            default: cue_stall <= ($urandom_range(0, 15) < 10);
        endcase
    end

    always @(posedge clk) begin
        cue_t want;
        if (rst_n && cue_valid && !cue_stall) begin
            if (cue_fifo.size() == 0) begin
                report("unexpected cue word", cue.regime, 0);
            end
            else begin
                want = cue_fifo.pop_front();
                if (cue.regime != want.regime) report("regime", cue.regime, want.regime);
                if (cue.left_gain != want.left_gain)
                    report("left_gain", cue.left_gain, want.left_gain);
                if (cue.right_gain != want.right_gain)
                    report("right_gain", cue.right_gain, want.right_gain);
                if (cue.tone_period != want.tone_period)
                    report("tone_period", cue.tone_period, want.tone_period);
                if (cue.pulse_period != want.pulse_period)
                    report("pulse_period", cue.pulse_period, want.pulse_period);
                if (cue.pwm_on_time != want.pwm_on_time)
                    report("pwm_on_time", cue.pwm_on_time, want.pwm_on_time);
                if (cue.ramp_time != want.ramp_time)
                    report("ramp_time", cue.ramp_time, want.ramp_time);
                if (want.regime <= REGIME_WARN)
                    regime_hits[want.regime]++;
            end
            cues_seen++;
        end
    end

    initial begin
        #2ms;
        $display("FAILURE");
        $finish;
    end

    initial begin
        cfg = '{cruise: 16'sd1280, reference: 16'sd2560, stall_angle: 16'sd3840,
                warn: 16'sd3584, bias: 16'sd0, full_scale: 15'd5120, fps: 18'd48000};
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_defaults();
        test_extreme_config();
        test_random_settings();
        $display("%0d sample words sent, %0d cue words checked under default, extreme",
                 words_sent, cues_seen);
        $display("and random thresholds; regimes seen: cruise %0d fast %0d onspeed %0d "
                 , regime_hits[0], regime_hits[1], regime_hits[2],
                 "slow %0d warning %0d", regime_hits[3], regime_hits[4]);
        if (mismatches == 0 && cue_fifo.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
